FILE: rtl/glcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcs_pkg
// Shared commands, register indexes and controller/datapath link types for
// the gray level contrast stretch unit.
// ----------------------------------------------------------------------------
package glcs_pkg;

  // Item commands
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ACCUM = 2'd1;
  localparam logic [1:0] CMD_XFORM = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRAY_LOW    = 2'd0;
  localparam logic [1:0] CFG_GRAY_HIGH   = 2'd1;
  localparam logic [1:0] CFG_AUTO_LEVELS = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;    // item accepted: update statistics, latch pixel and levels
    logic prep;    // form midpoint, distance, divisor and multiplier
    logic mul;     // form product, load divider
    logic step;    // one restoring divider step
    logic finish;  // apply gain or loss, load output register
  } glcs_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic bypass;    // result known without division
    logic out_free;  // output register can take a new item this cycle
  } glcs_sts_t;

endpackage

FILE: rtl/gray_level_contrast_stretch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray_level_contrast_stretch_unit
// Linear contrast stretch of gray pixels with running min/max statistics.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries a command and a pixel:
// clear resets the running min/max, accumulate folds the pixel into them,
// transform produces one stretched pixel on the output channel
// (out_valid_o/out_ready_i). Unused command codes are dropped.
// Levels come from gray_low/gray_high, or from the running min/max when
// auto_levels is set; write them through cfg_we_i/cfg_idx_i/cfg_data_i
// only while the unit is idle.
// Clear and accumulate update the statistics when accepted. A transform
// steps through prepare, multiply, the divider steps and the final clamp,
// the restoring divider retiring one quotient bit per cycle;
// inverted or zero-span levels skip the divider. One item is in work
// at a time; a new item is taken once the previous one has left the
// datapath, even if its result still waits at the output.
// Reset restores gray_low = 0, gray_high = all ones, auto mode off,
// min = all ones, max = 0. If the receiver stalls, the result holds in
// the output register and a following transform waits before it.
// ----------------------------------------------------------------------------
module gray_level_contrast_stretch_unit
  import glcs_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [PIXEL_BITS-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            cmd_i,
  input  logic [PIXEL_BITS-1:0] pixel_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] pixel_out_o
);

  glcs_ctl_t ctl;
  glcs_sts_t sts;

  glcs_ctrl #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_xform_i (cmd_i == CMD_XFORM),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  glcs_dpath #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd_i),
    .pixel_in_i  (pixel_in_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o)
  );

endmodule

FILE: rtl/glcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcs_ctrl
// Sequencer for the contrast stretch: accepts items, walks a transform
// through prepare, multiply, the divider steps and the final clamp.
// ----------------------------------------------------------------------------
module glcs_ctrl
  import glcs_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_xform_i,
  output logic      in_ready_o,
  input  glcs_sts_t sts_i,
  output glcs_ctl_t ctl_o
);

  localparam int DIV_STEPS = 2 * PIXEL_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ctl_o      = '0;
    ctl_o.take = accept;
    case (state_q)
      S_IDLE: begin
        if (accept && in_xform_i) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        ctl_o.prep = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        ctl_o.mul = 1'b1;
        cnt_d     = '0;
        // skip the divider when the result is already known
        state_d   = sts_i.bypass ? S_DONE : S_DIV;
      end
      S_DIV: begin
        ctl_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register frees up
        if (sts_i.out_free) begin
          ctl_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_div_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL && !sts_i.bypass) |=> (state_q == S_DIV && cnt_q == '0))
    else $error("divider not started from step zero");

  a_div_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q == CNT_LAST) |=> (state_q == S_DONE))
    else $error("divider ran past its last step");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.finish |-> sts_i.out_free)
    else $error("result loaded over a waiting item");

endmodule

FILE: rtl/glcs_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcs_dpath
// Datapath: configuration and statistics registers, level selection,
// one multiplier, a one-bit-per-cycle restoring divider and the output stage.
// ----------------------------------------------------------------------------
module glcs_dpath
  import glcs_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [PIXEL_BITS-1:0] cfg_data_i,
  input  logic [1:0]            cmd_i,
  input  logic [PIXEL_BITS-1:0] pixel_in_i,
  input  glcs_ctl_t             ctl_i,
  output glcs_sts_t             sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] pixel_out_o
);

  localparam int P = PIXEL_BITS;
  localparam int W = 2 * PIXEL_BITS;
  localparam logic [P-1:0] PIX_MAX = '1;

  // configuration and statistics
  logic [P-1:0] gray_low_q, gray_high_q;
  logic         auto_q;
  logic [P-1:0] seen_min_q, seen_max_q;

  // per item
  logic [P-1:0] v_q, lo_q, hi_q;
  logic [P-1:0] dist_q, den_q, mult_q;
  logic         above_q, bypass_q;
  logic [P-1:0] byp_val_q;
  logic [W-1:0] quo_q;
  logic [P-1:0] rem_q;
  logic [P-1:0] out_q;
  logic         out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray_low_q  <= '0;
      gray_high_q <= PIX_MAX;
      auto_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRAY_LOW:    gray_low_q  <= cfg_data_i;
        CFG_GRAY_HIGH:   gray_high_q <= cfg_data_i;
        CFG_AUTO_LEVELS: auto_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_min_q <= PIX_MAX;
      seen_max_q <= '0;
    end else if (ctl_i.take) begin
      if (cmd_i == CMD_CLEAR) begin
        seen_min_q <= PIX_MAX;
        seen_max_q <= '0;
      end else if (cmd_i == CMD_ACCUM) begin
        if (pixel_in_i > seen_max_q) seen_max_q <= pixel_in_i;
        if (pixel_in_i < seen_min_q) seen_min_q <= pixel_in_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      v_q  <= pixel_in_i;
      lo_q <= auto_q ? seen_min_q : gray_low_q;
      hi_q <= auto_q ? seen_max_q : gray_high_q;
    end
  end

  // prepare: midpoint, side, distance, divisor, multiplier, early result
  logic [P:0]   mid_sum;
  logic [P-1:0] mid, dist_d, den, mult, byp_val;
  logic         above, bypass;

  always_comb begin
    mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
    mid     = mid_sum[P:1];
    above   = (v_q >= mid);
    dist_d  = above ? (v_q - mid) : (mid - v_q);
    den     = above ? (hi_q - mid) : (mid - lo_q);
    mult    = above ? (PIX_MAX - hi_q) : lo_q;
    bypass  = 1'b0;
    byp_val = v_q;
    if (lo_q > hi_q) begin
      bypass  = 1'b1;
      byp_val = v_q;
    end else if (den == '0) begin
      // zero span: saturate unless the pixel sits on the midpoint
      bypass  = 1'b1;
      byp_val = above ? ((dist_d == '0) ? v_q : PIX_MAX) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.prep) begin
      dist_q    <= dist_d;
      den_q     <= den;
      mult_q    <= mult;
      above_q   <= above;
      bypass_q  <= bypass;
      byp_val_q <= byp_val;
    end
  end

  // restoring divider step
  logic [P:0]   rem_sh;
  logic [P+1:0] diff;
  logic         ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    ge     = !diff[P+1];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      quo_q <= W'(dist_q) * W'(mult_q);
      rem_q <= '0;
    end else if (ctl_i.step) begin
      quo_q <= {quo_q[W-2:0], ge};
      rem_q <= ge ? diff[P-1:0] : rem_sh[P-1:0];
    end
  end

  // apply gain or loss with clamping
  logic [W:0]   sum;
  logic [P-1:0] result;

  always_comb begin
    sum = {1'b0, quo_q} + {{(W + 1 - P){1'b0}}, v_q};
    if (bypass_q) begin
      result = byp_val_q;
    end else if (above_q) begin
      result = (|sum[W:P]) ? PIX_MAX : sum[P-1:0];
    end else begin
      result = (quo_q > {{(W - P){1'b0}}, v_q}) ? '0 : (v_q - quo_q[P-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.finish) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.bypass   = bypass_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = out_q;

  a_stats_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_min_q > seen_max_q) |-> (seen_min_q == PIX_MAX && seen_max_q == '0))
    else $error("running min above max after accumulation");

  a_gain_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.finish && !bypass_q && above_q) |=> (out_q >= v_q))
    else $error("upper half pixel got darker");

  a_loss_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.finish && !bypass_q && !above_q) |=> (out_q <= v_q))
    else $error("lower half pixel got brighter");

endmodule
